// ----- hdl/assert_macros.svh -----
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define V3A_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define V3A_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hdl/v3a_pkg.sv -----
package v3a_pkg;

  localparam int DATA_W        = 32;
  localparam int MODE_W        = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MIN_NORM_W    = 17;
  localparam int NORM_IN_W     = 64;
  localparam int SQ_STAGES     = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int MAG_W         = 67;

  localparam logic [MIN_NORM_W-1:0] MIN_NORM_RST = 17'd1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MIN_NORM = 3'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_DOT, MODE_NORM, MODE_NORMALIZE, MODE_ADD,
    MODE_SUB, MODE_SCALE, MODE_CROSS, MODE_SKEW
  } mode_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } satval_t;

  // clip a sign-magnitude value to the signed 32-bit range
  function automatic satval_t sat_sm(input logic neg, input logic [MAG_W-1:0] mag);
    satval_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > MAG_W'(33'h080000000)) begin
        r.sat = 1'b1;
        r.val = 32'h80000000;
      end else begin
        r.val = ~mag[DATA_W-1:0] + 32'd1;
      end
    end else begin
      if (mag > MAG_W'(32'h7FFFFFFF)) begin
        r.sat = 1'b1;
        r.val = 32'h7FFFFFFF;
      end else begin
        r.val = mag[DATA_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ----- hdl/v3a_lane.sv -----
module v3a_lane #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  v3a_pkg::mode_t        mode,
  input  logic signed [31:0]    m0_a,
  input  logic signed [31:0]    m0_b,
  input  logic signed [31:0]    m1_a,
  input  logic signed [31:0]    m1_b,
  input  logic signed [31:0]    add_a,
  input  logic signed [31:0]    add_b,
  output logic signed [64:0]    prod_o,
  output logic [31:0]           vec_o,
  output logic                  vsat_o
);

  v3a_pkg::mode_t     mode_r;
  logic signed [63:0] p0_r, p1_r;
  logic signed [32:0] as_r;
  logic signed [64:0] prod_r;
  logic [31:0]        vec_r;
  logic               vsat_r;

  logic signed [64:0] diff;
  logic [64:0]        dmag;
  logic [32:0]        amag;
  v3a_pkg::satval_t   psat, asat;

  // stage 1: products and the plain add or subtract
  always_ff @(posedge clk) begin
    if (en) begin
      mode_r <= mode;
      p0_r   <= m0_a * m0_b;
      if (mode == v3a_pkg::MODE_CROSS) begin
        p1_r <= m1_a * m1_b;
      end else begin
        p1_r <= '0;
      end
      if (mode == v3a_pkg::MODE_SUB) begin
        as_r <= {add_a[31], add_a} - {add_b[31], add_b};
      end else begin
        as_r <= {add_a[31], add_a} + {add_b[31], add_b};
      end
    end
  end

  // stage 2: difference of products, truncate toward zero and clip, or clip the add or subtract
  always_comb begin
    diff = {p0_r[63], p0_r} - {p1_r[63], p1_r};
    dmag = diff[64] ? (65'd0 - diff) : diff;
    psat = v3a_pkg::sat_sm(diff[64], v3a_pkg::MAG_W'(dmag >> FRAC_BITS));
    amag = as_r[32] ? (33'd0 - as_r) : as_r;
    asat = v3a_pkg::sat_sm(as_r[32], v3a_pkg::MAG_W'(amag));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= diff;
      if (mode_r == v3a_pkg::MODE_ADD || mode_r == v3a_pkg::MODE_SUB) begin
        vec_r  <= asat.val;
        vsat_r <= asat.sat;
      end else begin
        vec_r  <= psat.val;
        vsat_r <= psat.sat;
      end
    end
  end

  assign prod_o = prod_r;
  assign vec_o  = vec_r;
  assign vsat_o = vsat_r;

endmodule

// ----- hdl/v3a_isqrt.sv -----
module v3a_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] val,
  output logic [31:0] root
);

  localparam int N = v3a_pkg::SQ_STAGES;

  logic [35:0] rem_r   [N];
  logic [31:0] root_r  [N];
  logic [63:0] v_r     [N];
  logic [35:0] rem_nxt [N];
  logic [31:0] root_nxt[N];
  logic [63:0] v_nxt   [N];

  // one result bit per stage, two radicand bits brought down each time
  always_comb begin
    logic [35:0] pr;
    logic [31:0] pq;
    logic [63:0] pv;
    logic [35:0] sh;
    logic [35:0] trial;
    logic        ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        pr = '0;
        pq = '0;
        pv = val;
      end else begin
        pr = rem_r[k-1];
        pq = root_r[k-1];
        pv = v_r[k-1];
      end
      sh          = {pr[33:0], pv[63:62]};
      trial       = {2'b00, pq, 2'b01};
      ge          = (sh >= trial);
      rem_nxt[k]  = ge ? (sh - trial) : sh;
      root_nxt[k] = {pq[30:0], ge};
      v_nxt[k]    = {pv[61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        v_r[k]    <= v_nxt[k];
      end
    end
  end

  assign root = root_r[N-1];

endmodule

// ----- hdl/v3a_div.sv -----
module v3a_div #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [31:0]             mag,
  input  logic [31:0]             den,
  output logic [32+FRAC_BITS-1:0] quo
);

  localparam int DW = 32 + FRAC_BITS;

  logic [31:0]   rem_r   [DW];
  logic [31:0]   den_r   [DW];
  logic [DW-1:0] dvd_r   [DW];
  logic [DW-1:0] quo_r   [DW];
  logic [31:0]   rem_nxt [DW];
  logic [31:0]   den_nxt [DW];
  logic [DW-1:0] dvd_nxt [DW];
  logic [DW-1:0] quo_nxt [DW];

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [31:0]   pr;
    logic [31:0]   pn;
    logic [DW-1:0] pd;
    logic [DW-1:0] pq;
    logic [32:0]   sh;
    logic [32:0]   dif;
    logic          ge;
    for (int k = 0; k < DW; k++) begin
      if (k == 0) begin
        pr = '0;
        pn = den;
        pd = {mag, {FRAC_BITS{1'b0}}};
        pq = '0;
      end else begin
        pr = rem_r[k-1];
        pn = den_r[k-1];
        pd = dvd_r[k-1];
        pq = quo_r[k-1];
      end
      sh         = {pr, pd[DW-1]};
      dif        = sh - {1'b0, pn};
      ge         = (sh >= {1'b0, pn});
      rem_nxt[k] = ge ? dif[31:0] : sh[31:0];
      den_nxt[k] = pn;
      dvd_nxt[k] = {pd[DW-2:0], 1'b0};
      quo_nxt[k] = {pq[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DW; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_nxt[k];
        dvd_r[k] <= dvd_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo = quo_r[DW-1];

endmodule

// ----- hdl/vector3_alu.sv -----
// three-component fixed-point vector unit. each request carries two signed
// vectors a and b, a scale factor and a mode in in_tuser; the unit returns the
// dot product, norm, normalized a, a+b, a-b, scaled a, a x b, or the
// skew-symmetric matrix of a as three row results (tlast on the third).
// products are exact and truncated toward zero, overflow clips and sets the
// saturated flag. the datapath is a pipeline (Q16.16 at the default FRAC_BITS):
// the two lane stages, a merge stage, the 32-stage square root and the
// one-bit-per-stage divider, then the output register. one request enters per
// cycle while the pipeline advances; a skew request holds the input while its
// rows drain, and a stalled result stops the whole pipeline. min_norm sits at
// byte address 0 of the cfg port.
module vector3_alu #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request: a_x, a_y, a_z, b_x, b_y, b_z, scale_factor (32 bits each)
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [223:0]                       in_tdata,
  // request: mode
  input  logic [v3a_pkg::MODE_W-1:0]         in_tuser,
  // result: out_x, out_y, out_z, out_scalar (32 bits each)
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [127:0]                       out_tdata,
  // result: ok, saturated
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [v3a_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [v3a_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [v3a_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int SQ = v3a_pkg::SQ_STAGES;
  localparam int MW = v3a_pkg::MIN_NORM_W;
  localparam logic [1:0] LAST_ROW = 2'd2;

  typedef struct packed {
    v3a_pkg::mode_t   mode;
    logic [2:0][31:0] a;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             sat;
    logic [31:0]      nrm;
  } meta_t;

  // negate with clipping of the most negative value
  function automatic v3a_pkg::satval_t neg_sat(input logic [31:0] v);
    v3a_pkg::satval_t r;
    if (v == 32'h80000000) begin
      r.sat = 1'b1;
      r.val = 32'h7FFFFFFF;
    end else begin
      r.sat = 1'b0;
      r.val = ~v + 32'd1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [MW-1:0] min_norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_norm_r <= v3a_pkg::MIN_NORM_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == v3a_pkg::ADDR_MIN_NORM) begin
      min_norm_r <= cfg_pwdata[MW-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == v3a_pkg::ADDR_MIN_NORM) ?
                      {{(v3a_pkg::CFG_DATA_W-MW){1'b0}}, min_norm_r} : '0;

  // ---------------------------------------------------------------- flow
  logic adv;
  logic o_vld_r;
  logic [1:0] row_r;
  v3a_pkg::mode_t o_mode_r;

  // the whole pipeline moves unless a result is waiting that is not taken as the last row
  assign adv       = !o_vld_r || (out_tready && out_tlast);
  assign in_tready = adv;

  // ---------------------------------------------------------------- lanes
  logic signed [31:0] va [3];
  logic signed [31:0] vb [3];
  logic signed [31:0] vs;
  v3a_pkg::mode_t     in_mode;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = in_tdata[32*i +: 32];
      vb[i] = in_tdata[96 + 32*i +: 32];
    end
    vs      = in_tdata[223:192];
    in_mode = v3a_pkg::mode_t'(in_tuser);
  end

  logic signed [64:0] lane_prod [3];
  logic [31:0]        lane_vec  [3];
  logic               lane_vsat [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic signed [31:0] op_a, op_b;

    // first multiplier operands by mode
    always_comb begin
      case (in_mode)
        v3a_pkg::MODE_NORM, v3a_pkg::MODE_NORMALIZE: begin
          op_a = va[i];
          op_b = va[i];
        end
        v3a_pkg::MODE_SCALE: begin
          op_a = va[i];
          op_b = vs;
        end
        v3a_pkg::MODE_CROSS: begin
          op_a = va[J];
          op_b = vb[K];
        end
        default: begin
          op_a = va[i];
          op_b = vb[i];
        end
      endcase
    end

    v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .en     (adv),
      .mode   (in_mode),
      .m0_a   (op_a),
      .m0_b   (op_b),
      .m1_a   (va[K]),
      .m1_b   (vb[J]),
      .add_a  (va[i]),
      .add_b  (vb[i]),
      .prod_o (lane_prod[i]),
      .vec_o  (lane_vec[i]),
      .vsat_o (lane_vsat[i])
    );
  end

  // ---------------------------------------------------------------- merge
  meta_t m1_r, m2_r, m3_r;
  meta_t m1_nxt, m3_nxt;
  logic  v1_r, v2_r, v3_r;
  logic [63:0] ss3_r;

  logic signed [66:0] dsum;
  logic [66:0]        dmag;
  v3a_pkg::satval_t   dsat;
  logic               vec_mode;

  always_comb begin
    dsum = {{2{lane_prod[0][64]}}, lane_prod[0]} +
           {{2{lane_prod[1][64]}}, lane_prod[1]} +
           {{2{lane_prod[2][64]}}, lane_prod[2]};
    dmag = dsum[66] ? (67'd0 - dsum) : dsum;
    dsat = v3a_pkg::sat_sm(dsum[66], dmag >> FRAC_BITS);
    vec_mode = (m2_r.mode == v3a_pkg::MODE_ADD)   || (m2_r.mode == v3a_pkg::MODE_SUB) ||
               (m2_r.mode == v3a_pkg::MODE_SCALE) || (m2_r.mode == v3a_pkg::MODE_CROSS);

    m1_nxt      = '0;
    m1_nxt.mode = in_mode;
    for (int i = 0; i < 3; i++) begin
      m1_nxt.a[i] = va[i];
    end

    m3_nxt = m2_r;
    for (int i = 0; i < 3; i++) begin
      m3_nxt.r[i] = vec_mode ? lane_vec[i] : 32'd0;
    end
    if (m2_r.mode == v3a_pkg::MODE_DOT) begin
      m3_nxt.sc  = dsat.val;
      m3_nxt.sat = dsat.sat;
    end else begin
      m3_nxt.sc  = '0;
      m3_nxt.sat = vec_mode && (lane_vsat[0] || lane_vsat[1] || lane_vsat[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= m1_nxt;
      m2_r <= m1_r;
      m3_r <= m3_nxt;
      // squares are never negative, the low 64 bits hold the whole sum
      ss3_r <= dsum[63:0];
    end
  end

  // ---------------------------------------------------------------- sqrt
  logic [31:0] root;
  meta_t       msq_r [SQ];
  logic [SQ-1:0] vsq_r;

  v3a_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .val  (ss3_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      msq_r[0] <= m3_r;
      for (int k = 1; k < SQ; k++) begin
        msq_r[k] <= msq_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- divide
  meta_t         mdv_r [DW];
  meta_t         mdv0_nxt;
  logic [DW-1:0] vdv_r;
  logic [DW-1:0] quo [3];
  logic [31:0]   amag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = msq_r[SQ-1].a[i][31] ? (32'd0 - msq_r[SQ-1].a[i]) : msq_r[SQ-1].a[i];
    end
    mdv0_nxt     = msq_r[SQ-1];
    mdv0_nxt.nrm = root;
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (adv),
      .mag (amag[i]),
      .den (root),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mdv_r[0] <= mdv0_nxt;
      for (int k = 1; k < DW; k++) begin
        mdv_r[k] <= mdv_r[k-1];
      end
    end
  end

  // valid bits for every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      vsq_r <= '0;
      vdv_r <= '0;
    end else if (adv) begin
      v1_r  <= in_tvalid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      vsq_r <= {vsq_r[SQ-2:0], v3_r};
      vdv_r <= {vdv_r[DW-2:0], vsq_r[SQ-1]};
    end
  end

  // ---------------------------------------------------------------- output
  meta_t            md;
  logic             nfail;
  v3a_pkg::satval_t qs [3];
  logic [2:0][31:0] ld_r;
  logic [31:0]      ld_sc;
  logic             ld_ok, ld_sat;

  logic [2:0][31:0] o_r_r;
  logic [2:0][31:0] o_a_r;
  logic [31:0]      o_sc_r;
  logic             o_ok_r, o_sat_r;

  always_comb begin
    md    = mdv_r[DW-1];
    nfail = (md.nrm == 32'd0) || (md.nrm < {{(32-MW){1'b0}}, min_norm_r});
    for (int i = 0; i < 3; i++) begin
      qs[i] = v3a_pkg::sat_sm(md.a[i][31], v3a_pkg::MAG_W'(quo[i]));
    end
    ld_r   = md.r;
    ld_sc  = md.sc;
    ld_ok  = 1'b1;
    ld_sat = md.sat;
    case (md.mode)
      v3a_pkg::MODE_NORM: begin
        ld_sc  = md.nrm[31] ? 32'h7FFFFFFF : md.nrm;
        ld_sat = md.nrm[31];
      end
      v3a_pkg::MODE_NORMALIZE: begin
        ld_sc = '0;
        if (nfail) begin
          ld_r   = '0;
          ld_ok  = 1'b0;
          ld_sat = 1'b0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            ld_r[i] = qs[i].val;
          end
          ld_sat = qs[0].sat || qs[1].sat || qs[2].sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r  <= 1'b0;
      row_r    <= '0;
      o_mode_r <= v3a_pkg::MODE_DOT;
    end else if (adv) begin
      o_vld_r  <= vdv_r[DW-1];
      row_r    <= '0;
      o_mode_r <= md.mode;
    end else if (out_tready) begin
      // next row of a skew matrix
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_r_r   <= ld_r;
      o_a_r   <= md.a;
      o_sc_r  <= ld_sc;
      o_ok_r  <= ld_ok;
      o_sat_r <= ld_sat;
    end
  end

  logic [31:0]      ox, oy, oz, osc;
  logic             osat;
  v3a_pkg::satval_t nx, ny, nz;

  always_comb begin
    nx   = neg_sat(o_a_r[0]);
    ny   = neg_sat(o_a_r[1]);
    nz   = neg_sat(o_a_r[2]);
    ox   = o_r_r[0];
    oy   = o_r_r[1];
    oz   = o_r_r[2];
    osc  = o_sc_r;
    osat = o_sat_r;
    if (o_mode_r == v3a_pkg::MODE_SKEW) begin
      osc = '0;
      case (row_r)
        2'd0: begin
          ox   = '0;
          oy   = nz.val;
          oz   = o_a_r[1];
          osat = nz.sat;
        end
        2'd1: begin
          ox   = o_a_r[2];
          oy   = '0;
          oz   = nx.val;
          osat = nx.sat;
        end
        default: begin
          ox   = ny.val;
          oy   = o_a_r[0];
          oz   = '0;
          osat = ny.sat;
        end
      endcase
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {osc, oz, oy, ox};
  assign out_tuser  = {osat, (o_mode_r == v3a_pkg::MODE_SKEW) ? 1'b1 : o_ok_r};
  assign out_tlast  = (o_mode_r != v3a_pkg::MODE_SKEW) || (row_r == LAST_ROW);

endmodule

// ----- hdl/v3a_checker.sv -----
`include "assert_macros.svh"

module v3a_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  // a stalled result keeps its payload
  `V3A_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // a failed normalize carries only zeros and no clip
  `V3A_ASSERT_SAME(a_fail_zero, out_tvalid && !out_tuser[0], out_tdata == 128'd0 && !out_tuser[1], "failed result not zero")

  // with no result waiting the input side is open
  `V3A_ASSERT_SAME(a_ready_empty, !out_tvalid, in_tready, "input blocked while output empty")

  // rows of a matrix follow without a gap
  `V3A_ASSERT_NEXT(a_rows_follow, out_tvalid && out_tready && !out_tlast, out_tvalid, "matrix row missing")

endmodule

bind vector3_alu v3a_checker u_v3a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

// vector unit check: requests go in on the in_ stream, results are compared
// field by field with a queue filled by a predictor of the arithmetic
module tb_top;

  localparam int PIPE_LAT = 100;  // pipeline depth plus margin

  typedef struct packed {
    logic [31:0] x, y, z, scalar;
    logic        ok, sat, last;
  } result_t;

  typedef struct {
    v3a_pkg::mode_t mode;
    logic [31:0] ax, ay, az, bx, by, bz, sf;
    logic        chk;   // typed-in expectation present
    logic [31:0] ex, ey, ez, es;
    logic        eok, esat;
  } vec_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [223:0] in_tdata = '0;
  logic [v3a_pkg::MODE_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [v3a_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [v3a_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [v3a_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  always #5 clk = ~clk;

  vector3_alu u_dut (.*);

  result_t    expected_q[$];
  logic [16:0] min_norm_m;
  int         errors = 0;
  logic       hold_off = 1'b0;  // receiver held for a long stretch
  int unsigned rx_wait = 0;     // cycles left in a long receiver gap

  // ---------------- predictor ----------------
  function automatic logic [31:0] clip(input logic neg, input logic [66:0] mag,
                                       inout logic sat);
    if (neg) begin
      if (mag > 67'h80000000) begin sat = 1'b1; return 32'h80000000; end
      return 32'(-mag);
    end
    if (mag > 67'h7FFFFFFF) begin sat = 1'b1; return 32'h7FFFFFFF; end
    return mag[31:0];
  endfunction

  function automatic logic [31:0] clip_s(input logic signed [66:0] v, inout logic sat);
    return clip(v < 0, v < 0 ? -v : v, sat);
  endfunction

  // sum of products truncated toward zero
  function automatic logic [31:0] prod_sum(input logic signed [66:0] v, inout logic sat);
    logic [66:0] m;
    m = (v < 0 ? -v : v) >> 16;
    return clip(v < 0, m, sat);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic predict_vector_op(input vec_req_t q);
    logic signed [66:0] a[3], b[3], s;
    logic [63:0] ss, n;
    logic [66:0] m;
    result_t r;
    logic rs;
    a[0] = $signed(q.ax); a[1] = $signed(q.ay); a[2] = $signed(q.az);
    b[0] = $signed(q.bx); b[1] = $signed(q.by); b[2] = $signed(q.bz);
    s = $signed(q.sf);
    r = '0;
    r.ok = 1'b1;
    r.last = 1'b1;
    case (q.mode)
      v3a_pkg::MODE_DOT: r.scalar = prod_sum(a[0]*b[0] + a[1]*b[1] + a[2]*b[2], r.sat);
      v3a_pkg::MODE_NORM, v3a_pkg::MODE_NORMALIZE: begin
        ss = 64'(a[0]*a[0]) + 64'(a[1]*a[1]) + 64'(a[2]*a[2]);
        n = root_floor(ss);
        if (q.mode == v3a_pkg::MODE_NORM) r.scalar = clip(1'b0, 67'(n), r.sat);
        else if (n == 0 || n < 64'(min_norm_m)) r.ok = 1'b0;
        else begin
          m = a[0] < 0 ? -a[0] : a[0]; r.x = clip(a[0] < 0, (m << 16) / n, r.sat);
          m = a[1] < 0 ? -a[1] : a[1]; r.y = clip(a[1] < 0, (m << 16) / n, r.sat);
          m = a[2] < 0 ? -a[2] : a[2]; r.z = clip(a[2] < 0, (m << 16) / n, r.sat);
        end
      end
      v3a_pkg::MODE_ADD: begin
        r.x = clip_s(a[0] + b[0], r.sat);
        r.y = clip_s(a[1] + b[1], r.sat);
        r.z = clip_s(a[2] + b[2], r.sat);
      end
      v3a_pkg::MODE_SUB: begin
        r.x = clip_s(a[0] - b[0], r.sat);
        r.y = clip_s(a[1] - b[1], r.sat);
        r.z = clip_s(a[2] - b[2], r.sat);
      end
      v3a_pkg::MODE_SCALE: begin
        r.x = prod_sum(a[0]*s, r.sat);
        r.y = prod_sum(a[1]*s, r.sat);
        r.z = prod_sum(a[2]*s, r.sat);
      end
      v3a_pkg::MODE_CROSS: begin
        r.x = prod_sum(a[1]*b[2] - a[2]*b[1], r.sat);
        r.y = prod_sum(a[2]*b[0] - a[0]*b[2], r.sat);
        r.z = prod_sum(a[0]*b[1] - a[1]*b[0], r.sat);
      end
      v3a_pkg::MODE_SKEW: begin
        // three matrix rows, saturation tracked per row
        for (int row = 0; row < 3; row++) begin
          r = '0;
          r.ok = 1'b1;
          rs = 1'b0;
          if (row == 0) begin
            r.y = clip_s(-a[2], rs); r.z = clip_s(a[1], rs);
          end else if (row == 1) begin
            r.x = clip_s(a[2], rs); r.z = clip_s(-a[0], rs);
          end else begin
            r.x = clip_s(-a[1], rs); r.y = clip_s(a[0], rs);
          end
          r.sat = rs;
          r.last = (row == 2);
          expected_q.push_back(r);
        end
        return;
      end
      default: begin
      end
    endcase
    // typed-in rows must agree with the predictor too
    if (q.chk && ({r.x, r.y, r.z, r.scalar, r.ok, r.sat} !==
                  {q.ex, q.ey, q.ez, q.es, q.eok, q.esat})) begin
      $display("%0t predictor disagrees with table: exp %h act %h", $time,
               {q.ex, q.ey, q.ez, q.es, q.eok, q.esat},
               {r.x, r.y, r.z, r.scalar, r.ok, r.sat});
      errors++;
    end
    expected_q.push_back(r);
  endtask

  // ---------------- drivers ----------------
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  bit no_gaps = 1'b0;  // stretch with no idling

  task automatic send_request(input vec_req_t q);
    int unsigned g;
    g = no_gaps ? 0 : gap_len();
    repeat (g) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= q.mode;
    in_tdata  <= {q.sf, q.bz, q.by, q.bx, q.az, q.ay, q.ax};
    predict_vector_op(q);
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_min_norm(input logic [16:0] v);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= v3a_pkg::ADDR_MIN_NORM; cfg_pwdata <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    min_norm_m = v;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  // receiver: random stalls, a few long ones, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if (no_gaps) out_tready <= 1'b1;
    else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 39) == 0) begin
      rx_wait <= $urandom_range(10, 40);
      out_tready <= 1'b0;
    end else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // ---------------- checker ----------------
  always @(posedge clk) begin
    result_t act, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      act = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tdata[127:96],
             out_tuser[0], out_tuser[1], out_tlast};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, act);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (act.x !== exp_r.x) begin
          $display("%0t out_x exp %h act %h", $time, exp_r.x, act.x); errors++;
        end
        if (act.y !== exp_r.y) begin
          $display("%0t out_y exp %h act %h", $time, exp_r.y, act.y); errors++;
        end
        if (act.z !== exp_r.z) begin
          $display("%0t out_z exp %h act %h", $time, exp_r.z, act.z); errors++;
        end
        if (act.scalar !== exp_r.scalar) begin
          $display("%0t out_scalar exp %h act %h", $time, exp_r.scalar, act.scalar);
          errors++;
        end
        if (act.ok !== exp_r.ok) begin
          $display("%0t ok exp %b act %b", $time, exp_r.ok, act.ok); errors++;
        end
        if (act.sat !== exp_r.sat) begin
          $display("%0t saturated exp %b act %b", $time, exp_r.sat, act.sat); errors++;
        end
        if (act.last !== exp_r.last) begin
          $display("%0t last exp %b act %b", $time, exp_r.last, act.last); errors++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic vec_req_t mk(input v3a_pkg::mode_t md, input logic [31:0] ax, ay, az,
                                  bx, by, bz, sf);
    vec_req_t q;
    q = '{mode: md, ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz, sf: sf,
          chk: 1'b0, ex: 0, ey: 0, ez: 0, es: 0, eok: 1'b1, esat: 1'b0};
    return q;
  endfunction

  function automatic vec_req_t mk_exp(input vec_req_t q, input logic [31:0] ex, ey, ez,
                                      es, input logic eok, esat);
    q.chk = 1'b1; q.ex = ex; q.ey = ey; q.ez = ez; q.es = es; q.eok = eok; q.esat = esat;
    return q;
  endfunction

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h80000000 | $urandom_range(0, 3);
      2: return 32'h7FFFFFFF - $urandom_range(0, 3);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)) << 6;
    endcase
  endfunction

  function automatic vec_req_t rnd_req();
    return mk(v3a_pkg::mode_t'($urandom_range(0, 7)), rnd_val(), rnd_val(), rnd_val(),
              rnd_val(), rnd_val(), rnd_val(), rnd_val());
  endfunction

  localparam logic [31:0] MAXP = 32'h7FFFFFFF;
  localparam logic [31:0] MINN = 32'h80000000;
  localparam logic [31:0] ONE  = 32'h00010000;

  vec_req_t directed[$];

  initial begin
    min_norm_m = v3a_pkg::MIN_NORM_RST;
    // extremes, every mode, failing normalize, clipped negation
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_DOT, 0, 0, 0, 0, 0, 0, 0),
                              0, 0, 0, 0, 1, 0));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_DOT, ONE, ONE, ONE, ONE, ONE, ONE, 0),
                              0, 0, 0, 32'h30000, 1, 0));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_DOT, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, 0),
                              0, 0, 0, MAXP, 1, 1));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_DOT, MINN, MINN, MINN, MAXP, MAXP, MAXP, 0),
                              0, 0, 0, MINN, 1, 1));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_NORM, 0, 0, 0, 0, 0, 0, 0),
                              0, 0, 0, 0, 1, 0));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_NORM, 32'h30000, 32'h40000, 0, 0, 0, 0, 0),
                              0, 0, 0, 32'h50000, 1, 0));
    directed.push_back(mk(v3a_pkg::MODE_NORM, MINN, MINN, MINN, 0, 0, 0, 0));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_NORMALIZE, 0, 0, 0, 0, 0, 0, 0),
                              0, 0, 0, 0, 0, 0));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_NORMALIZE, ONE, 0, 0, 0, 0, 0, 0),
                              ONE, 0, 0, 0, 1, 0));
    directed.push_back(mk(v3a_pkg::MODE_NORMALIZE, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(v3a_pkg::MODE_NORMALIZE, MINN, MAXP, 32'hFFFFFFFF, 0, 0, 0, 0));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_ADD, MAXP, MINN, ONE, ONE, MINN, ONE, 0),
                              MAXP, MINN, 32'h20000, 0, 1, 1));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_SUB, MINN, MAXP, 0, ONE, MINN, 0, 0),
                              MINN, MAXP, 0, 0, 1, 1));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_SUB, 5, 5, 5, 5, 5, 5, 0),
                              0, 0, 0, 0, 1, 0));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_SCALE, ONE, 32'hFFFF0000, 32'h7,
                                 0, 0, 0, 32'h20000),
                              32'h20000, 32'hFFFE0000, 32'he, 0, 1, 0));
    directed.push_back(mk(v3a_pkg::MODE_SCALE, MINN, MAXP, 32'hFFFFFFFF, 0, 0, 0, MINN));
    directed.push_back(mk(v3a_pkg::MODE_SCALE, 32'hFFFFFFFF, 1, 3, 0, 0, 0, 1));
    directed.push_back(mk_exp(mk(v3a_pkg::MODE_CROSS, ONE, 0, 0, 0, ONE, 0, 0),
                              0, 0, ONE, 0, 1, 0));
    directed.push_back(mk(v3a_pkg::MODE_CROSS, MINN, MAXP, MINN, MAXP, MINN, MAXP, 0));
    directed.push_back(mk(v3a_pkg::MODE_SKEW, ONE, 32'h20000, 32'h30000, 0, 0, 0, 0));
    directed.push_back(mk(v3a_pkg::MODE_SKEW, MINN, MINN, MINN, MAXP, MAXP, MAXP, MAXP));
    directed.push_back(mk(v3a_pkg::MODE_SKEW, MAXP, 0, MINN, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i]);
    drain();

    // normalize threshold at zero, then at 17'h10000 with norms just below and at it
    write_min_norm(17'd0);
    send_request(mk(v3a_pkg::MODE_NORMALIZE, 0, 0, 0, 0, 0, 0, 0));
    send_request(mk(v3a_pkg::MODE_NORMALIZE, 1, 0, 0, 0, 0, 0, 0));
    drain();
    write_min_norm(17'h10000);
    send_request(mk(v3a_pkg::MODE_NORMALIZE, 32'hFFFF, 0, 0, 0, 0, 0, 0));
    send_request(mk(v3a_pkg::MODE_NORMALIZE, 0, 32'hFFFF0000, 0, 0, 0, 0, 0));
    drain();

    // long receiver hold-off while the sender keeps offering past the pipeline depth
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        no_gaps = 1'b1;
        for (int i = 0; i < 100; i++) send_request(rnd_req());
        no_gaps = 1'b0;
      end
    join
    drain();

    // random phases across several thresholds
    for (int ph = 0; ph < 4; ph++) begin
      write_min_norm(ph == 0 ? 17'd1 : ph == 1 ? 17'h1FFFF & 17'h10000 :
                     17'($urandom_range(0, 65536)));
      no_gaps = (ph == 2);
      for (int i = 0; i < 25; i++) send_request(rnd_req());
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
